>>> rtl/htfd_pkg.sv
// Shared types, constants and CRC function for the humidity/temperature frame decoder.
`default_nettype none

package htfd_pkg;

  // CRC-8 over each 16-bit word: polynomial 0x31, seed 0xFF, no reflection
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Byte positions within one response frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Scaling: centi = offset + round(span * raw / FULL_SCALE)
  localparam int TEMP_SPAN   = 17500;
  localparam int TEMP_OFFSET = -4500;
  localparam int HUM_SPAN    = 12500;
  localparam int HUM_OFFSET  = -600;
  localparam int FULL_SCALE  = 65535;
  localparam int HALF_SCALE  = 32767;

  localparam int CENTI_W = 15;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_CRC = 2'd1,
    ST_HUM_CRC  = 2'd2
  } status_t;

  // One complete, checked frame handed to the scaling stage
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    status_t     status;
  } frame_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/htfd_scale.sv
// Two-stage scaling of a checked frame: multiply, then divide by full scale and add offset.
`default_nettype none

module htfd_scale (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 frame_valid,
  input  wire htfd_pkg::frame_t                     frame,
  output logic                                      frame_ready,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [htfd_pkg::CENTI_W-1:0]       out_temperature_centi,
  output logic signed [htfd_pkg::CENTI_W-1:0]       out_humidity_centi,
  output logic [1:0]                                out_status
);

  // round(p / 65535) for p below 2^31 - 32767, no exact halves possible
  function automatic logic [htfd_pkg::CENTI_W-1:0] div_round(input logic [30:0] p);
    logic [30:0] m;
    logic [14:0] q0;
    logic [16:0] r;
    logic [14:0] q;
    m  = p + 31'(htfd_pkg::HALF_SCALE);
    q0 = m[30:16];
    // m = q0*65535 + (q0 + low half); remainder stays below twice the divisor
    r  = {1'b0, m[15:0]} + 17'(q0);
    q  = q0 + 15'(r >= 17'(htfd_pkg::FULL_SCALE));
    return q;
  endfunction

  logic                        a_valid_r;
  logic [30:0]                 a_prod_t_r;
  logic [30:0]                 a_prod_h_r;
  htfd_pkg::status_t           a_status_r;

  logic                        out_valid_r;
  logic signed [14:0]          temp_r;
  logic signed [14:0]          hum_r;
  htfd_pkg::status_t           status_r;

  logic                        out_free;
  logic                        a_ready;
  logic [14:0]                 q_t;
  logic [14:0]                 q_h;
  logic signed [14:0]          temp_nxt;
  logic signed [14:0]          hum_nxt;

  assign out_free    = !out_valid_r || !out_stall;
  assign a_ready     = !a_valid_r || out_free;
  assign frame_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && frame_valid) begin
      a_prod_t_r <= 31'(frame.temp_word) * 31'(htfd_pkg::TEMP_SPAN);
      a_prod_h_r <= 31'(frame.hum_word) * 31'(htfd_pkg::HUM_SPAN);
      a_status_r <= frame.status;
    end
  end

  always_comb begin
    q_t = div_round(a_prod_t_r);
    q_h = div_round(a_prod_h_r);
    if (a_status_r == htfd_pkg::ST_OK) begin
      temp_nxt = $signed(q_t + 15'(htfd_pkg::TEMP_OFFSET));
      hum_nxt  = $signed(q_h + 15'(htfd_pkg::HUM_OFFSET));
    end else begin
      temp_nxt = '0;
      hum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= a_valid_r;
    end
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (out_free && a_valid_r) begin
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
      status_r <= a_status_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_r;
  assign out_humidity_centi    = hum_r;
  assign out_status            = status_r;

endmodule

`default_nettype wire

>>> rtl/humidity_temp_frame_decoder.sv
// Humidity/temperature sensor response decoder: CRC check and scaling to hundredths.
//
// Input channel: one response byte per transfer (in_rx_byte), in sensor order:
// temperature MSB, LSB, CRC, humidity MSB, LSB, CRC. in_frame_start marks byte 0
// and abandons any partial frame; without it the count wraps after six bytes.
// A byte can be taken in every cycle while in_stall is low.
// Result channel: one transfer per complete frame with status (0 ok, 1 temperature
// CRC bad, 2 humidity CRC bad) and signed temperature/humidity in hundredths.
// Both values read 0 when either CRC is bad.
// After the sixth byte is taken, the frame is registered after the multipliers and
// then after the divide-by-65535 stage, which drives the result.
// Throughput: one byte per cycle unless the two-stage scaling pipeline stalls the input.
// Reset (rst_n low, synchronous) restarts the byte count, reseeds the CRC and
// empties the pipeline. A stall on the result side holds the result; the input
// stalls only once both pipeline stages are full.
`default_nettype none

module humidity_temp_frame_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_rx_byte,
  input  wire logic                            in_frame_start,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [htfd_pkg::CENTI_W-1:0]  out_temperature_centi,
  output logic signed [htfd_pkg::CENTI_W-1:0]  out_humidity_centi,
  output logic [1:0]                           out_status
);

  logic [2:0]        byte_idx_r;
  logic [7:0]        crc_r;
  logic [15:0]       temp_word_r;
  logic [15:0]       hum_word_r;
  logic              temp_good_r;

  logic [2:0]        byte_idx_nxt;
  logic [7:0]        crc_nxt;
  logic [15:0]       temp_word_nxt;
  logic [15:0]       hum_word_nxt;
  logic              temp_good_nxt;

  logic [2:0]        pos;
  logic              accept;
  logic              frame_ready;
  logic              frame_valid;
  htfd_pkg::frame_t  frame;

  assign in_stall = !frame_ready;
  assign accept   = in_valid && frame_ready;

  always_comb begin
    pos = byte_idx_r;
    if (in_frame_start || byte_idx_r > htfd_pkg::POS_H_CRC) begin
      pos = htfd_pkg::POS_T_MSB;
    end

    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_good_nxt = temp_good_r;
    byte_idx_nxt  = pos + 3'd1;

    case (pos)
      htfd_pkg::POS_T_MSB: begin
        crc_nxt       = htfd_pkg::crc8_feed(htfd_pkg::CRC_INIT, in_rx_byte);
        temp_word_nxt = {in_rx_byte, 8'h00};
      end
      htfd_pkg::POS_T_LSB: begin
        crc_nxt       = htfd_pkg::crc8_feed(crc_r, in_rx_byte);
        temp_word_nxt = {temp_word_r[15:8], in_rx_byte};
      end
      htfd_pkg::POS_T_CRC: begin
        temp_good_nxt = (crc_r == in_rx_byte);
      end
      htfd_pkg::POS_H_MSB: begin
        crc_nxt      = htfd_pkg::crc8_feed(htfd_pkg::CRC_INIT, in_rx_byte);
        hum_word_nxt = {in_rx_byte, 8'h00};
      end
      htfd_pkg::POS_H_LSB: begin
        crc_nxt      = htfd_pkg::crc8_feed(crc_r, in_rx_byte);
        hum_word_nxt = {hum_word_r[15:8], in_rx_byte};
      end
      default: begin
        byte_idx_nxt = htfd_pkg::POS_T_MSB;
      end
    endcase

    frame_valid     = accept && (pos == htfd_pkg::POS_H_CRC);
    frame.temp_word = temp_word_r;
    frame.hum_word  = hum_word_r;
    // Temperature check wins when both words are bad
    if (!temp_good_r) begin
      frame.status = htfd_pkg::ST_TEMP_CRC;
    end else if (crc_r != in_rx_byte) begin
      frame.status = htfd_pkg::ST_HUM_CRC;
    end else begin
      frame.status = htfd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= htfd_pkg::POS_T_MSB;
      crc_r       <= htfd_pkg::CRC_INIT;
      temp_word_r <= '0;
      hum_word_r  <= '0;
      temp_good_r <= 1'b0;
    end else if (accept) begin
      byte_idx_r  <= byte_idx_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_word_r  <= hum_word_nxt;
      temp_good_r <= temp_good_nxt;
    end
  end

  htfd_scale u_scale (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .frame_valid           (frame_valid),
    .frame                 (frame),
    .frame_ready           (frame_ready),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_status            (out_status)
  );

endmodule

`default_nettype wire

>>> rtl/htfd_checker.sv
// Port-level checks for the frame decoder and their bind to the top level.
`default_nettype none

module htfd_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic signed [htfd_pkg::CENTI_W-1:0]   out_temperature_centi,
  input wire logic signed [htfd_pkg::CENTI_W-1:0]   out_humidity_centi,
  input wire logic [1:0]                            out_status
);

  // A stalled result stays and does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_temperature_centi) && $stable(out_humidity_centi))
    else $error("result changed while stalled");

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // Failed CRC drops both measurements to zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != htfd_pkg::ST_OK |->
      out_temperature_centi == 15'sd0 && out_humidity_centi == 15'sd0)
    else $error("non-zero value with bad CRC");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == htfd_pkg::ST_OK |->
      out_temperature_centi >= -15'sd4500 && out_temperature_centi <= 15'sd13000 &&
      out_humidity_centi >= -15'sd600 && out_humidity_centi <= 15'sd11900)
    else $error("scaled value out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_temperature_centi (out_temperature_centi),
  .out_humidity_centi    (out_humidity_centi),
  .out_status            (out_status)
);

`default_nettype wire

>>> tb/humidity_temp_frame_decoder_tb.sv
// Self-checking testbench for the humidity/temperature frame decoder.
module humidity_temp_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BYTES  = 650;
  localparam int QUIET_FROM   = 580;
  localparam int HOLD_AT      = 250;
  localparam int LONG_HOLD    = 48;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 50;

  localparam logic [1:0] CORRUPT_NONE = 2'b00;
  localparam logic [1:0] CORRUPT_TEMP = 2'b01;
  localparam logic [1:0] CORRUPT_HUM  = 2'b10;
  localparam logic [1:0] CORRUPT_BOTH = 2'b11;

  typedef struct packed {
    logic signed [htfd_pkg::CENTI_W-1:0] temp;
    logic signed [htfd_pkg::CENTI_W-1:0] hum;
    htfd_pkg::status_t                   status;
  } reading_t;

  typedef struct packed {
    logic [7:0]                          data;
    logic                                start;
    logic                                typed;
    logic signed [htfd_pkg::CENTI_W-1:0] temp;
    logic signed [htfd_pkg::CENTI_W-1:0] hum;
    htfd_pkg::status_t                   status;
  } row_t;

  // Typed readings sit on the sixth byte of each frame
  localparam row_t DIRECTED [26] = '{
    // all-zero words, good CRCs, flagged start
    '{8'h00, 1'b1, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h81, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h81, 1'b0, 1'b1, -15'sd4500, -15'sd600, htfd_pkg::ST_OK},
    // full-scale words, count wraps without a start flag
    '{8'hFF, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'hAC, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'hAC, 1'b0, 1'b1, 15'sd13000, 15'sd11900, htfd_pkg::ST_OK},
    // partial frame, abandoned by the next start
    '{8'h12, 1'b1, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h34, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    // both CRCs bad: temperature wins
    '{8'h00, 1'b1, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b1, 15'sd0, 15'sd0, htfd_pkg::ST_TEMP_CRC},
    // good temperature, bad humidity CRC
    '{8'hBE, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'hEF, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h92, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 15'sd0, 15'sd0, htfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b1, 15'sd0, 15'sd0, htfd_pkg::ST_HUM_CRC}
  };

  logic                                clk            = 1'b0;
  logic                                rst_n          = 1'b0;
  logic                                in_valid       = 1'b0;
  logic                                in_stall;
  logic [7:0]                          in_rx_byte     = 8'h00;
  logic                                in_frame_start = 1'b0;
  logic                                out_valid;
  logic                                out_stall      = 1'b0;
  logic signed [htfd_pkg::CENTI_W-1:0] out_temperature_centi;
  logic signed [htfd_pkg::CENTI_W-1:0] out_humidity_centi;
  logic [1:0]                          out_status;

  // Decoder state mirrored by the testbench
  logic [2:0]  frame_pos  = htfd_pkg::POS_T_MSB;
  logic [7:0]  word_crc_q = htfd_pkg::CRC_INIT;
  logic [15:0] temp_raw   = 16'h0000;
  logic [15:0] hum_raw    = 16'h0000;
  logic        temp_good  = 1'b0;

  reading_t readings_due [$];
  int       errors      = 0;
  int       bytes_taken = 0;
  int       idle_cycles = 0;
  int       n_ok        = 0;
  int       n_temp_bad  = 0;
  int       n_hum_bad   = 0;
  bit       quiet       = 1'b0;
  bit       hold_req    = 1'b0;

  humidity_temp_frame_decoder u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .in_frame_start        (in_frame_start),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_status            (out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bitwise CRC-8, data MSB first
  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      if (r[7] ^ data[i]) begin
        r = {r[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc_next(crc_next(htfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // round(offset + span*raw/65535), half away from zero, kept to CENTI_W bits
  function automatic logic signed [htfd_pkg::CENTI_W-1:0] to_centi(input int offset,
                                                                   input int span,
                                                                   input logic [15:0] raw);
    longint num;
    longint q;
    num = longint'(offset) * htfd_pkg::FULL_SCALE + longint'(span) * longint'(raw);
    if (num >= 0) begin
      q = (num + htfd_pkg::HALF_SCALE) / htfd_pkg::FULL_SCALE;
    end else begin
      q = -((-num + htfd_pkg::HALF_SCALE) / htfd_pkg::FULL_SCALE);
    end
    return q[htfd_pkg::CENTI_W-1:0];
  endfunction

  // Advance the mirrored state by one byte; returns 1 when a reading falls due
  function automatic bit decode_byte(input logic [7:0] data, input logic start,
                                     output reading_t r);
    logic [2:0] pos;
    logic       hum_good;
    pos = (start || frame_pos > htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : frame_pos;
    r = '0;
    case (pos)
      htfd_pkg::POS_T_MSB: begin
        word_crc_q = crc_next(htfd_pkg::CRC_INIT, data);
        temp_raw   = {data, 8'h00};
      end
      htfd_pkg::POS_T_LSB: begin
        word_crc_q = crc_next(word_crc_q, data);
        temp_raw   = {temp_raw[15:8], data};
      end
      htfd_pkg::POS_T_CRC: begin
        temp_good = (word_crc_q == data);
      end
      htfd_pkg::POS_H_MSB: begin
        word_crc_q = crc_next(htfd_pkg::CRC_INIT, data);
        hum_raw    = {data, 8'h00};
      end
      htfd_pkg::POS_H_LSB: begin
        word_crc_q = crc_next(word_crc_q, data);
        hum_raw    = {hum_raw[15:8], data};
      end
      default: begin
      end
    endcase
    if (pos != htfd_pkg::POS_H_CRC) begin
      frame_pos = pos + 3'd1;
      return 1'b0;
    end
    frame_pos = htfd_pkg::POS_T_MSB;
    hum_good  = (word_crc_q == data);
    if (!temp_good) begin
      r.status = htfd_pkg::ST_TEMP_CRC;
    end else if (!hum_good) begin
      r.status = htfd_pkg::ST_HUM_CRC;
    end else begin
      r.status = htfd_pkg::ST_OK;
      r.temp   = to_centi(htfd_pkg::TEMP_OFFSET, htfd_pkg::TEMP_SPAN, temp_raw);
      r.hum    = to_centi(htfd_pkg::HUM_OFFSET, htfd_pkg::HUM_SPAN, hum_raw);
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // Offer one byte, hold it until the transfer, then update the mirror
  task automatic send_byte(input logic [7:0] data, input logic start, input logic typed,
                           input reading_t want);
    reading_t got;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= data;
    in_frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_taken++;
    if (decode_byte(data, start, got)) begin
      readings_due.push_back(typed ? want : got);
    end
  endtask

  task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input logic start, input logic [1:0] corrupt, input int len);
    logic [7:0] frame_bytes [6];
    reading_t   blank;
    blank = '0;
    frame_bytes[0] = t_raw[15:8];
    frame_bytes[1] = t_raw[7:0];
    frame_bytes[2] = word_crc(t_raw);
    frame_bytes[3] = h_raw[15:8];
    frame_bytes[4] = h_raw[7:0];
    frame_bytes[5] = word_crc(h_raw);
    if ((corrupt & CORRUPT_TEMP) != CORRUPT_NONE) begin
      frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(1, 255));
    end
    if ((corrupt & CORRUPT_HUM) != CORRUPT_NONE) begin
      frame_bytes[5] = frame_bytes[5] ^ 8'($urandom_range(1, 255));
    end
    for (int k = 0; k < len; k++) begin
      send_byte(frame_bytes[k], (k == 0) ? start : 1'b0, 1'b0, blank);
    end
  endtask

  // Bias towards the ends of the scale
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 15));
      3:       return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [1:0] pick_corruption();
    case ($urandom_range(0, 19))
      15, 16:  return CORRUPT_TEMP;
      17, 18:  return CORRUPT_HUM;
      19:      return CORRUPT_BOTH;
      default: return CORRUPT_NONE;
    endcase
  endfunction

  // Result side: short random stalls, one long hold on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    reading_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        report_mismatch("reading with none due, status", int'(out_status), 0);
      end else begin
        due = readings_due.pop_front();
        if (out_status !== 2'(due.status)) begin
          report_mismatch("status", int'(out_status), int'(due.status));
        end
        if (out_temperature_centi !== due.temp) begin
          report_mismatch("temperature", int'(out_temperature_centi), int'($signed(due.temp)));
        end
        if (out_humidity_centi !== due.hum) begin
          report_mismatch("humidity", int'(out_humidity_centi), int'($signed(due.hum)));
        end
        case (due.status)
          htfd_pkg::ST_OK:       n_ok++;
          htfd_pkg::ST_TEMP_CRC: n_temp_bad++;
          default:               n_hum_bad++;
        endcase
      end
    end
  end

  // Give up when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d readings outstanding",
               IDLE_LIMIT, readings_due.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reading_t want;
    bit       need_start;
    bit       hold_done;
    int       kind;
    need_start = 1'b0;
    hold_done  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      want = '{DIRECTED[i].temp, DIRECTED[i].hum, DIRECTED[i].status};
      send_byte(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].typed, want);
    end

    while (bytes_taken < TOTAL_BYTES) begin
      if (!hold_done && bytes_taken >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      quiet = (bytes_taken >= QUIET_FROM);
      kind  = $urandom_range(0, 9);
      if (kind < 8) begin
        send_frame(pick_word(), pick_word(), need_start || ($urandom_range(0, 1) == 1),
                   pick_corruption(), 6);
        need_start = 1'b0;
      end else if (kind == 8) begin
        // truncated frame
        send_frame(pick_word(), pick_word(), 1'b1, pick_corruption(), $urandom_range(1, 5));
        need_start = 1'b1;
      end else begin
        // loose bytes, start flag at random
        repeat ($urandom_range(1, 4)) begin
          want = '0;
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, want);
        end
        need_start = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; checked %0d good readings,", bytes_taken, n_ok);
    $display("%0d temperature CRC faults and %0d humidity CRC faults", n_temp_bad, n_hum_bad);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
